FILE: src/alarm_match_snooze_controller_defines.svh
// assertion macros for the alarm match and snooze controller
// used by the top level only; no other dependencies
`ifndef ALARM_MATCH_SNOOZE_CONTROLLER_DEFINES_SVH
`define ALARM_MATCH_SNOOZE_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked from reset release on
`define AMSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked from reset release on
`define AMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/amsc_pkg.sv
// types, constants and helpers for the alarm match and snooze controller
// no dependencies
package amsc_pkg;

  localparam int unsigned MinW    = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MinW-1:0] MinPerDay  = 11'd1440;
  localparam logic [MinW-1:0] MinNone    = 11'h7FF;
  localparam logic [5:0]      SecNone    = 6'd63;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstAlarm  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondAlarm = 2'd1;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       ack_pressed;
  } amsc_item_t;

  typedef struct packed {
    logic            buzzer_on;
    logic            ringing;
    logic [MinW-1:0] shown_minutes;
    logic            screen_refresh;
    logic            auto_snoozed;
    logic            acknowledged;
    logic [7:0]      snoozes_so_far;
  } amsc_result_t;

  typedef struct packed {
    logic [MinW-1:0] first_alarm_minutes;
    logic [MinW-1:0] second_alarm_minutes;
  } amsc_cfg_t;

  // hour * 60 + minute, at most 1923 for any input pattern
  function automatic logic [MinW-1:0] amsc_minutes(input logic [4:0] hour,
                                                   input logic [5:0] minute);
    logic [MinW-1:0] h;
    h = MinW'(hour);
    return (h << 6) - (h << 2) + MinW'(minute);
  endfunction

  // following minute, wrapped at the end of the day
  function automatic logic [MinW-1:0] amsc_next_minute(input logic [MinW-1:0] cur);
    logic [MinW-1:0] nxt;
    nxt = cur + 11'd1;
    if (nxt >= MinPerDay) begin
      nxt = nxt - MinPerDay;
    end
    return nxt;
  endfunction

endpackage

FILE: src/amsc_if.sv
// valid/ready channel interfaces for polls, results and configuration writes
// depends on amsc_pkg
interface amsc_poll_if;
  import amsc_pkg::*;
  logic       valid;
  logic       ready;
  logic [4:0] hour_now;
  logic [5:0] minute_now;
  logic [5:0] second_now;
  logic       ack_pressed;

  modport source (output valid, hour_now, minute_now, second_now, ack_pressed,
                  input ready);
  modport sink   (input valid, hour_now, minute_now, second_now, ack_pressed,
                  output ready);
endinterface

interface amsc_result_if;
  import amsc_pkg::*;
  logic            valid;
  logic            ready;
  logic            buzzer_on;
  logic            ringing;
  logic [MinW-1:0] shown_minutes;
  logic            screen_refresh;
  logic            auto_snoozed;
  logic            acknowledged;
  logic [7:0]      snoozes_so_far;

  modport source (output valid, buzzer_on, ringing, shown_minutes, screen_refresh,
                  auto_snoozed, acknowledged, snoozes_so_far, input ready);
  modport sink   (input valid, buzzer_on, ringing, shown_minutes, screen_refresh,
                  auto_snoozed, acknowledged, snoozes_so_far, output ready);
endinterface

interface amsc_cfg_if;
  import amsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [MinW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/amsc_cfg_regs.sv
// alarm time register file written over the configuration channel
// depends on amsc_pkg and amsc_if
module amsc_cfg_regs
  import amsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  amsc_cfg_if.sink     cfg_i,
  output amsc_cfg_t    cfg_o
);

  amsc_cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgFirstAlarm:  cfg_d.first_alarm_minutes  = cfg_i.data;
        CfgSecondAlarm: cfg_d.second_alarm_minutes = cfg_i.data;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{first_alarm_minutes: MinNone, second_alarm_minutes: MinNone};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/amsc_core.sv
// alarm state and its update for one poll
// depends on amsc_pkg
module amsc_core
  import amsc_pkg::*;
#(
  parameter int unsigned AUTO_SNOOZE_SECONDS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  amsc_item_t   item_i,
  input  amsc_cfg_t    cfg_i,
  output amsc_result_t result_o
);

  localparam logic [7:0] AutoLimit = 8'(AUTO_SNOOZE_SECONDS);

  logic            active_q, active_d;
  logic            ack_latch_q, ack_latch_d;
  logic [MinW-1:0] trigger_q, trigger_d;
  logic [MinW-1:0] snooze_min_q, snooze_min_d;
  logic            armed_q, armed_d;
  logic [7:0]      tally_q, tally_d;
  logic [7:0]      ring_sec_q, ring_sec_d;
  logic [5:0]      seen_sec_q, seen_sec_d;
  logic            screen_done_q, screen_done_d;

  logic [MinW-1:0] cur;
  logic            hit1, hit2, snooze_hit, fire;

  // time of day and alarm matches
  always_comb begin
    cur  = amsc_minutes(item_i.hour_now, item_i.minute_now);
    hit1 = (cfg_i.first_alarm_minutes < MinPerDay) && (cfg_i.first_alarm_minutes == cur);
    hit2 = (cfg_i.second_alarm_minutes < MinPerDay) && (cfg_i.second_alarm_minutes == cur);
    snooze_hit = armed_q && (snooze_min_q == cur) && (item_i.second_now == 6'd0);
  end

  // next state and result for the poll
  always_comb begin
    active_d      = active_q;
    ack_latch_d   = ack_latch_q && (cur == trigger_q);
    trigger_d     = trigger_q;
    snooze_min_d  = snooze_min_q;
    armed_d       = armed_q;
    tally_d       = tally_q;
    ring_sec_d    = ring_sec_q;
    seen_sec_d    = seen_sec_q;
    screen_done_d = screen_done_q;
    result_o      = '0;

    fire = !active_q && !ack_latch_d && (hit1 || hit2 || snooze_hit);
    if (fire) begin
      active_d      = 1'b1;
      screen_done_d = 1'b0;
      armed_d       = 1'b0;
      trigger_d     = cur;
    end

    if (active_d) begin
      result_o.shown_minutes = hit1 ? cfg_i.first_alarm_minutes
                             : hit2 ? cfg_i.second_alarm_minutes : snooze_min_q;
      result_o.buzzer_on = 1'b1;
      if (!screen_done_d) begin
        result_o.screen_refresh = 1'b1;
        screen_done_d = 1'b1;
      end
      // count changes of the second while ringing
      if (seen_sec_q != item_i.second_now) begin
        seen_sec_d = item_i.second_now;
        ring_sec_d = ring_sec_q + 8'd1;
      end
      if (ring_sec_d >= AutoLimit) begin
        // unanswered: snooze to the next minute, overrides a press
        active_d     = 1'b0;
        ring_sec_d   = 8'd0;
        snooze_min_d = amsc_next_minute(cur);
        armed_d      = 1'b1;
        tally_d      = tally_q + 8'd1;
        ack_latch_d  = 1'b1;
        result_o.buzzer_on    = 1'b0;
        result_o.auto_snoozed = 1'b1;
      end else if (item_i.ack_pressed) begin
        active_d      = 1'b0;
        screen_done_d = 1'b0;
        ack_latch_d   = 1'b1;
        result_o.buzzer_on    = 1'b0;
        result_o.acknowledged = 1'b1;
      end
    end

    result_o.ringing        = active_d;
    result_o.snoozes_so_far = tally_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      ack_latch_q   <= 1'b0;
      trigger_q     <= MinNone;
      snooze_min_q  <= MinNone;
      armed_q       <= 1'b0;
      tally_q       <= 8'd0;
      ring_sec_q    <= 8'd0;
      seen_sec_q    <= SecNone;
      screen_done_q <= 1'b0;
    end else if (step_i) begin
      active_q      <= active_d;
      ack_latch_q   <= ack_latch_d;
      trigger_q     <= trigger_d;
      snooze_min_q  <= snooze_min_d;
      armed_q       <= armed_d;
      tally_q       <= tally_d;
      ring_sec_q    <= ring_sec_d;
      seen_sec_q    <= seen_sec_d;
      screen_done_q <= screen_done_d;
    end
  end

endmodule

FILE: src/alarm_match_snooze_controller.sv
// Alarm match and snooze controller, top level: poll register, alarm core, result register.
// Takes one poll transfer per clock while the result side takes transfers, and gives one
// result transfer per poll, in order. A poll is registered on transfer; when the result
// register is free or draining the core steps on it, its result is loaded into the result
// register and offered from there. The alarm state is updated between the two registers,
// which sets the rate of one poll per clock while the result side takes transfers. A
// waiting result holds the state update back, but one further poll is still taken into
// the poll register.
// Depends on amsc_pkg, amsc_if, amsc_cfg_regs, amsc_core and the defines header.
`include "alarm_match_snooze_controller_defines.svh"

module alarm_match_snooze_controller
  import amsc_pkg::*;
#(
  parameter int unsigned AUTO_SNOOZE_SECONDS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  amsc_cfg_if.sink      cfg_i,
  amsc_poll_if.sink     poll_i,
  amsc_result_if.source result_o
);

  amsc_cfg_t    cfg;
  amsc_item_t   item_q;
  logic         in_valid_q;
  amsc_result_t res_d, res_q;
  logic         out_valid_q;
  logic         step;

  // the core advances when the result register is free or draining
  assign step         = in_valid_q && (!out_valid_q || result_o.ready);
  assign poll_i.ready = !in_valid_q || step;

  amsc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  amsc_core #(
    .AUTO_SNOOZE_SECONDS (AUTO_SNOOZE_SECONDS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // poll register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      item_q <= '{hour_now: poll_i.hour_now, minute_now: poll_i.minute_now,
                  second_now: poll_i.second_now, ack_pressed: poll_i.ack_pressed};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.buzzer_on      = res_q.buzzer_on;
  assign result_o.ringing        = res_q.ringing;
  assign result_o.shown_minutes  = res_q.shown_minutes;
  assign result_o.screen_refresh = res_q.screen_refresh;
  assign result_o.auto_snoozed   = res_q.auto_snoozed;
  assign result_o.acknowledged   = res_q.acknowledged;
  assign result_o.snoozes_so_far = res_q.snoozes_so_far;

  // checks on the core and the pipeline control
  `AMSC_ASSERT_NOW(a_buzz_only_ringing, clk_i, rst_ni,
                   out_valid_q && res_q.buzzer_on, res_q.ringing,
                   "buzzer on without ringing")
  `AMSC_ASSERT_NOW(a_silence_ends_ring, clk_i, rst_ni,
                   out_valid_q && (res_q.auto_snoozed || res_q.acknowledged),
                   !res_q.ringing && !res_q.buzzer_on &&
                   !(res_q.auto_snoozed && res_q.acknowledged),
                   "snooze or press left the alarm ringing")
  `AMSC_ASSERT_NEXT(a_poll_held, clk_i, rst_ni,
                    in_valid_q && !step, in_valid_q && $stable(item_q),
                    "stalled poll lost")
  `AMSC_ASSERT_NEXT(a_step_fills, clk_i, rst_ni, step, out_valid_q,
                    "result dropped after core step")

endmodule
